// File: rtl/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Shared types and constants of the HTML stream tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hst_pkg;

  // document length cap and the derived offset and length limits
  localparam longint unsigned MAX_LEN = 64'd65536;
  localparam logic [15:0] OFS_CAP = (MAX_LEN - 64'd1 < 64'd65535) ?
                                    16'(MAX_LEN - 64'd1) : 16'hFFFF;
  localparam logic [16:0] LEN_CAP = {1'b0, OFS_CAP} + 17'd1;

  localparam int unsigned LOOKAHEAD = 8;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       doc_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [16:0] token_length;
    logic        run_last;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [16:0] len;
    logic        ovf;
  } res_t;

endpackage

// File: rtl/hst_if.sv
// ----------------------------------------------------------------------------
// hst_in_if / hst_out_if
// Valid/ready channels for document bytes and for tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hst_in_if import hst_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hst_out_if import hst_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/html_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// html_stream_tokenizer
// Output path: a token is registered in held_r, then in the output register out_r.
// Throughput: one byte per cycle without output back-pressure; each further
//   window decision of the same byte (drain after a mismatch, a mode change,
//   the second token of "/>") and the end-of-document flush delay the next byte.
// Reset: synchronous, active low; text mode, empty window, offsets at zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module html_stream_tokenizer import hst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hst_in_if.sink    in_chan,
  hst_out_if.source out_chan
);

  localparam logic [3:0] M_TEXT    = 4'd0;
  localparam logic [3:0] M_OPEN    = 4'd1;
  localparam logic [3:0] M_ENDNAME = 4'd2;
  localparam logic [3:0] M_COMMENT = 4'd3;
  localparam logic [3:0] M_CDATA   = 4'd4;
  localparam logic [3:0] M_TAGNAME = 4'd5;
  localparam logic [3:0] M_ATTR    = 4'd6;
  localparam logic [3:0] M_ATTRS   = 4'd7;
  localparam logic [3:0] M_VLEAD   = 4'd8;
  localparam logic [3:0] M_VALUE   = 4'd9;

  localparam logic [2:0] K_TEXT    = 3'd0;
  localparam logic [2:0] K_TSTART  = 3'd1;
  localparam logic [2:0] K_TEND    = 3'd2;
  localparam logic [2:0] K_ANAME   = 3'd3;
  localparam logic [2:0] K_OPTION  = 3'd4;
  localparam logic [2:0] K_AVALUE  = 3'd5;
  localparam logic [2:0] K_COMMENT = 3'd6;
  localparam logic [2:0] K_CDATA   = 3'd7;

  localparam logic [1:0] MT_MISS = 2'd0;
  localparam logic [1:0] MT_HIT  = 2'd1;
  localparam logic [1:0] MT_WAIT = 2'd2;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // byte 0 of each pattern sits in the lowest lane
  localparam logic [7:0][7:0] PAT_CDATA  = "[ATADC[!";
  localparam logic [7:0][7:0] PAT_COPEN  = {40'h0, "--!"};
  localparam logic [7:0][7:0] PAT_CCLOSE = {40'h0, ">--"};
  localparam logic [7:0][7:0] PAT_DCLOSE = {40'h0, ">]]"};
  localparam logic [7:0][7:0] PAT_SLASH  = {48'h0, ">/"};

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
           (c == 8'h0B) || (c == 8'h0C);
  endfunction

  function automatic logic [1:0] win_match(input logic [7:0][7:0] w,
                                           input logic [3:0] cnt,
                                           input logic [7:0][7:0] pat,
                                           input logic [3:0] n,
                                           input logic at_end);
    logic miss;
    miss = 1'b0;
    for (int i = 0; i < LOOKAHEAD; i++) begin
      if ((4'(i) < n) && (4'(i) < cnt) && (w[i] != pat[i])) miss = 1'b1;
    end
    if (miss) return MT_MISS;
    else if (cnt >= n) return MT_HIT;
    else if (at_end) return MT_MISS;
    else return MT_WAIT;
  endfunction

  // parser state
  logic [3:0]        mode_r;
  logic [7:0][7:0]   win_b_r;
  logic [7:0][15:0]  win_o_r;
  logic [3:0]        win_cnt_r;
  logic [16:0]       byte_ofs_r;
  logic [15:0]       slice_start_r;
  logic [16:0]       slice_len_r;
  logic [15:0]       tname_start_r;
  logic [16:0]       tname_len_r;
  logic              in_quote_r;
  logic [7:0]        quote_r;
  logic [7:0]        prev_r;
  logic              np_r;
  logic              ovf_r;
  logic              busy_r;
  logic              step_end_r;
  logic              flush_r;

  // result staging
  logic      held_v_r;
  logic      held_final_r;
  res_t      held_r;
  logic      out_v_r;
  out_item_t out_r;

  logic acc, idle, out_free, dec_active, eng_active, eng_go, eng_emit, eng_done;
  logic held_move, held_last;
  res_t eng_res;

  logic [7:0][7:0]  eff_b;
  logic [7:0][15:0] eff_o;
  logic [3:0]       eff_cnt;
  logic             eff_end;
  logic [7:0]       front_c;
  logic [15:0]      front_o;
  logic [15:0]      pos;
  logic             ovf_hit, ovf_eff;

  logic [15:0] s_ext_start, t_ext_start;
  logic [16:0] s_ext_len, t_ext_len;
  logic [1:0]  m_cdata, m_copen, m_cclose, m_dclose, m_slash;

  logic [3:0]  d_mode, d_cons;
  logic        d_wait, d_emit;
  logic [2:0]  d_kind;
  logic [15:0] d_start, d_sstart, d_tstart;
  logic [16:0] d_len, d_slen, d_tlen;
  logic        d_inq, d_np;
  logic [7:0]  d_qc, d_prev;

  logic [7:0][7:0]  nw_b;
  logic [7:0][15:0] nw_o;
  logic [3:0]       nw_cnt;
  logic             step_over;
  logic             fl_emit;

  assign idle     = !busy_r && !flush_r;
  assign out_free = !out_v_r || out_chan.ready;
  assign in_chan.ready = idle && (!held_v_r || out_free);
  assign acc      = in_chan.valid && in_chan.ready;

  assign ovf_hit = byte_ofs_r > {1'b0, OFS_CAP};
  assign pos     = ovf_hit ? OFS_CAP : byte_ofs_r[15:0];
  assign ovf_eff = ovf_r || (acc && ovf_hit);

  // window as seen by this cycle's decision, with the arriving byte appended
  always_comb begin
    for (int i = 0; i < LOOKAHEAD; i++) begin
      eff_b[i] = (acc && (4'(i) == win_cnt_r)) ? in_chan.data.byte_in : win_b_r[i];
      eff_o[i] = (acc && (4'(i) == win_cnt_r)) ? pos : win_o_r[i];
    end
    eff_cnt = acc ? win_cnt_r + 4'd1 : win_cnt_r;
    eff_end = acc ? in_chan.data.doc_end : step_end_r;
  end

  assign front_c = eff_b[0];
  assign front_o = eff_o[0];

  assign s_ext_start = (slice_len_r == 17'd0) ? front_o : slice_start_r;
  assign s_ext_len   = (slice_len_r < LEN_CAP) ? slice_len_r + 17'd1 : slice_len_r;
  assign t_ext_start = (tname_len_r == 17'd0) ? front_o : tname_start_r;
  assign t_ext_len   = (tname_len_r < LEN_CAP) ? tname_len_r + 17'd1 : tname_len_r;

  assign m_cdata  = win_match(eff_b, eff_cnt, PAT_CDATA, 4'd8, eff_end);
  assign m_copen  = win_match(eff_b, eff_cnt, PAT_COPEN, 4'd3, eff_end);
  assign m_cclose = win_match(eff_b, eff_cnt, PAT_CCLOSE, 4'd3, eff_end);
  assign m_dclose = win_match(eff_b, eff_cnt, PAT_DCLOSE, 4'd3, eff_end);
  assign m_slash  = win_match(eff_b, eff_cnt, PAT_SLASH, 4'd2, eff_end);

  // one decision on the front of the window
  always_comb begin
    logic [1:0] mc;
    d_mode   = mode_r;
    d_cons   = 4'd0;
    d_wait   = 1'b0;
    d_emit   = 1'b0;
    d_kind   = K_TEXT;
    d_start  = slice_start_r;
    d_len    = slice_len_r;
    d_sstart = slice_start_r;
    d_slen   = slice_len_r;
    d_tstart = tname_start_r;
    d_tlen   = tname_len_r;
    d_inq    = in_quote_r;
    d_qc     = quote_r;
    d_prev   = prev_r;
    d_np     = np_r;
    mc       = (mode_r == M_COMMENT) ? m_cclose : m_dclose;
    unique case (mode_r)
      M_TEXT: begin
        d_cons = 4'd1;
        if (front_c != CH_LT) begin
          d_sstart = s_ext_start;
          d_slen   = s_ext_len;
        end else begin
          d_emit   = slice_len_r != 17'd0;
          d_kind   = K_TEXT;
          d_sstart = '0;
          d_slen   = '0;
          d_mode   = M_OPEN;
        end
      end
      M_OPEN: begin
        if (front_c == CH_SLASH) begin
          d_cons = 4'd1;
          d_tlen = '0;
          d_mode = M_ENDNAME;
        end else if (m_cdata == MT_WAIT) begin
          d_wait = 1'b1;
        end else if (m_cdata == MT_HIT) begin
          d_cons   = 4'd8;
          d_sstart = '0;
          d_slen   = '0;
          d_mode   = M_CDATA;
        end else if (m_copen == MT_WAIT) begin
          d_wait = 1'b1;
        end else if (m_copen == MT_HIT) begin
          d_cons   = 4'd3;
          d_sstart = '0;
          d_slen   = '0;
          d_mode   = M_COMMENT;
        end else begin
          d_tlen = '0;
          d_np   = 1'b1;
          d_mode = M_TAGNAME;
        end
      end
      M_ENDNAME: begin
        d_cons = 4'd1;
        if (front_c == CH_GT) begin
          d_emit   = 1'b1;
          d_kind   = K_TEND;
          d_start  = tname_start_r;
          d_len    = tname_len_r;
          d_sstart = '0;
          d_slen   = '0;
          d_mode   = M_TEXT;
        end else begin
          d_tstart = t_ext_start;
          d_tlen   = t_ext_len;
        end
      end
      M_COMMENT, M_CDATA: begin
        if (mc == MT_WAIT) begin
          d_wait = 1'b1;
        end else if (mc == MT_HIT) begin
          d_emit   = 1'b1;
          d_kind   = (mode_r == M_COMMENT) ? K_COMMENT : K_CDATA;
          d_cons   = 4'd3;
          d_sstart = '0;
          d_slen   = '0;
          d_mode   = M_TEXT;
        end else begin
          d_cons   = 4'd1;
          d_sstart = s_ext_start;
          d_slen   = s_ext_len;
        end
      end
      M_TAGNAME: begin
        d_start = tname_start_r;
        d_len   = tname_len_r;
        if (front_c == CH_GT) begin
          d_emit   = np_r;
          d_kind   = K_TSTART;
          d_cons   = 4'd1;
          d_sstart = '0;
          d_slen   = '0;
          d_mode   = M_TEXT;
        end else if (m_slash == MT_WAIT) begin
          d_wait = 1'b1;
        end else if (m_slash == MT_HIT) begin
          // self-closing tag: start token first if not yet sent, end token on the next pass
          d_emit = 1'b1;
          if (np_r) begin
            d_kind = K_TSTART;
            d_np   = 1'b0;
          end else begin
            d_kind   = K_TEND;
            d_np     = 1'b1;
            d_cons   = 4'd2;
            d_sstart = '0;
            d_slen   = '0;
            d_mode   = M_TEXT;
          end
        end else if (is_ws(front_c)) begin
          d_emit   = np_r;
          d_kind   = K_TSTART;
          d_np     = 1'b0;
          d_cons   = 4'd1;
          d_sstart = '0;
          d_slen   = '0;
          d_mode   = M_ATTR;
        end else begin
          d_cons   = 4'd1;
          d_tstart = t_ext_start;
          d_tlen   = t_ext_len;
        end
      end
      M_ATTR: begin
        if (front_c == CH_EQ) begin
          d_emit   = 1'b1;
          d_kind   = K_ANAME;
          d_cons   = 4'd1;
          d_sstart = '0;
          d_slen   = '0;
          d_inq    = 1'b0;
          d_qc     = '0;
          d_prev   = '0;
          d_mode   = M_VLEAD;
        end else if (is_ws(front_c) || (front_c == CH_GT) || (m_slash == MT_HIT)) begin
          d_emit = slice_len_r != 17'd0;
          d_kind = K_OPTION;
          d_mode = M_ATTRS;
        end else if (m_slash == MT_WAIT) begin
          d_wait = 1'b1;
        end else begin
          d_cons   = 4'd1;
          d_sstart = s_ext_start;
          d_slen   = s_ext_len;
        end
      end
      M_ATTRS: begin
        if (is_ws(front_c)) begin
          d_cons   = 4'd1;
          d_sstart = '0;
          d_slen   = '0;
          d_mode   = M_ATTR;
        end else begin
          d_mode = M_TAGNAME;
        end
      end
      M_VLEAD: begin
        if (is_ws(front_c)) d_cons = 4'd1;
        else d_mode = M_VALUE;
      end
      default: begin
        d_kind = K_AVALUE;
        if (in_quote_r) begin
          d_cons   = 4'd1;
          d_sstart = s_ext_start;
          d_slen   = s_ext_len;
          if ((front_c == quote_r) && (prev_r != CH_BSL)) begin
            d_emit  = 1'b1;
            d_start = s_ext_start;
            d_len   = s_ext_len;
            d_mode  = M_ATTRS;
          end else begin
            d_prev = front_c;
          end
        end else if ((front_c == CH_DQ) || (front_c == CH_SQ)) begin
          d_inq    = 1'b1;
          d_qc     = front_c;
          d_cons   = 4'd1;
          d_sstart = s_ext_start;
          d_slen   = s_ext_len;
          d_prev   = front_c;
        end else if (is_ws(front_c) || (front_c == CH_GT)) begin
          d_emit = 1'b1;
          d_mode = M_ATTRS;
        end else begin
          d_cons   = 4'd1;
          d_sstart = s_ext_start;
          d_slen   = s_ext_len;
          d_prev   = front_c;
        end
      end
    endcase
  end

  // window after consuming the decided bytes
  always_comb begin
    int idx;
    idx = 0;
    for (int i = 0; i < LOOKAHEAD; i++) begin
      idx = i + int'(d_cons);
      if (idx < LOOKAHEAD) begin
        nw_b[i] = eff_b[idx[2:0]];
        nw_o[i] = eff_o[idx[2:0]];
      end else begin
        nw_b[i] = '0;
        nw_o[i] = '0;
      end
    end
  end

  assign nw_cnt    = eff_cnt - d_cons;
  assign step_over = d_wait || (nw_cnt == 4'd0);
  assign fl_emit   = (mode_r == M_TEXT) && (slice_len_r != 17'd0);

  assign dec_active = busy_r || acc;
  assign eng_active = flush_r || dec_active;
  assign eng_emit   = flush_r ? fl_emit : (dec_active && d_emit);
  assign eng_done   = flush_r || (dec_active && step_over && !eff_end);
  assign eng_go     = eng_active && (!eng_emit || !held_v_r || out_free);

  always_comb begin
    eng_res.kind  = flush_r ? K_TEXT : d_kind;
    eng_res.start = flush_r ? slice_start_r : d_start;
    eng_res.len   = flush_r ? slice_len_r : d_len;
    eng_res.ovf   = flush_r ? ovf_r : ovf_eff;
    if (eng_res.len == 17'd0) eng_res.start = front_o;
  end

  assign held_move = held_v_r && out_free &&
                     (held_final_r || (eng_go && (eng_emit || eng_done)));
  assign held_last = held_final_r || (eng_go && eng_done && !eng_emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= M_TEXT;
      win_cnt_r     <= '0;
      byte_ofs_r    <= '0;
      slice_start_r <= '0;
      slice_len_r   <= '0;
      tname_start_r <= '0;
      tname_len_r   <= '0;
      in_quote_r    <= 1'b0;
      quote_r       <= '0;
      prev_r        <= '0;
      np_r          <= 1'b1;
      ovf_r         <= 1'b0;
      busy_r        <= 1'b0;
      step_end_r    <= 1'b0;
      flush_r       <= 1'b0;
      held_v_r      <= 1'b0;
      held_final_r  <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      if (acc) begin
        if (!ovf_hit) byte_ofs_r <= byte_ofs_r + 17'd1;
        ovf_r      <= ovf_eff;
        step_end_r <= in_chan.data.doc_end;
      end
      if (dec_active && eng_go) begin
        mode_r        <= d_mode;
        win_cnt_r     <= nw_cnt;
        slice_start_r <= d_sstart;
        slice_len_r   <= d_slen;
        tname_start_r <= d_tstart;
        tname_len_r   <= d_tlen;
        in_quote_r    <= d_inq;
        quote_r       <= d_qc;
        prev_r        <= d_prev;
        np_r          <= d_np;
        busy_r        <= !step_over;
        flush_r       <= step_over && eff_end;
      end
      // end of document: back to the reset state
      if (flush_r && eng_go) begin
        mode_r        <= M_TEXT;
        win_cnt_r     <= '0;
        byte_ofs_r    <= '0;
        slice_start_r <= '0;
        slice_len_r   <= '0;
        tname_start_r <= '0;
        tname_len_r   <= '0;
        in_quote_r    <= 1'b0;
        quote_r       <= '0;
        prev_r        <= '0;
        np_r          <= 1'b1;
        ovf_r         <= 1'b0;
        step_end_r    <= 1'b0;
        flush_r       <= 1'b0;
      end
      if (eng_go && eng_emit) begin
        held_v_r     <= 1'b1;
        held_final_r <= eng_done;
      end else if (held_move) begin
        held_v_r     <= 1'b0;
        held_final_r <= 1'b0;
      end else if (eng_go && eng_done && held_v_r) begin
        held_final_r <= 1'b1;
      end
      if (held_move) out_v_r <= 1'b1;
      else if (out_chan.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_active && eng_go) begin
      win_b_r <= nw_b;
      win_o_r <= nw_o;
    end
    if (eng_go && eng_emit) held_r <= eng_res;
    if (held_move) begin
      out_r.token_kind   <= held_r.kind;
      out_r.token_start  <= held_r.start;
      out_r.token_length <= held_r.len;
      out_r.run_last     <= held_last;
      out_r.overflow     <= held_r.ovf;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_r;

endmodule
